FILE: rtl/primitive_point_coverage_test_unit_macros.svh
// Assertion macros shared by the point coverage test RTL.
`ifndef PRIMITIVE_POINT_COVERAGE_TEST_UNIT_MACROS_SVH
`define PRIMITIVE_POINT_COVERAGE_TEST_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PPCT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PPCT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ppct_pkg.sv
// Types, constants and helpers for the point coverage test block.
package ppct_pkg;

  localparam int MAX_TRIANGLES_DEF = 4096;

  localparam int COORD_W   = 16;
  localparam int TRACE_W   = 12;
  localparam int DIFF_W    = 18;
  localparam int PROD_W    = 36;
  localparam int SUM_W     = 37;
  localparam int CNT_W     = 14;
  localparam int TRI_W     = 13;
  localparam int TRI_CMP_W = 17;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 3;

  localparam logic [CNT_W-1:0]  VCOUNT_MAX      = '1;
  localparam int                COUNT_FIELD_MAX = 8191;
  localparam logic [STEP_W-1:0] MUL_STEPS       = 3'd6;

  typedef enum logic [1:0] {
    KIND_LIST,
    KIND_STRIP,
    KIND_FAN,
    KIND_ALWAYS
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL,
    ST_FIN
  } state_t;

  typedef enum logic {
    REG_TRACE_X,
    REG_TRACE_Y
  } reg_idx_t;

  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctrl_t;

  typedef logic signed [DIFF_W-1:0] opnd_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  function automatic opnd_t coord_ext(input logic [COORD_W-1:0] v);
    return opnd_t'($signed(v));
  endfunction

endpackage

FILE: rtl/ppct_apb.sv
// APB register bank holding the trace point.
module ppct_apb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppct_pkg::ADDR_W-1:0]   paddr,
  input  logic [ppct_pkg::DATA_W-1:0]   pwdata,
  output logic [ppct_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output logic [ppct_pkg::TRACE_W-1:0]  trace_x,
  output logic [ppct_pkg::TRACE_W-1:0]  trace_y
);
  import ppct_pkg::*;

  logic     wr;
  reg_idx_t sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_x <= '0;
      trace_y <= '0;
    end else if (wr) begin
      unique case (sel)
        REG_TRACE_X: trace_x <= pwdata[TRACE_W-1:0];
        REG_TRACE_Y: trace_y <= pwdata[TRACE_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_TRACE_X: prdata = DATA_W'(trace_x);
      REG_TRACE_Y: prdata = DATA_W'(trace_y);
      default:     prdata = '0;
    endcase
  end

endmodule

FILE: rtl/ppct_mac.sv
// Shared signed multiply and accumulate unit for the edge cross products.
module ppct_mac (
  input  logic                 clk,
  input  logic                 rst,
  input  ppct_pkg::mac_ctrl_t  ctrl,
  input  ppct_pkg::opnd_t      op_a,
  input  ppct_pkg::opnd_t      op_b,
  output logic                 res_valid,
  output ppct_pkg::prod_t      acc
);
  import ppct_pkg::*;

  mac_ctrl_t ctrl_q;
  prod_t     prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_q    <= '0;
      res_valid <= 1'b0;
    end else begin
      ctrl_q    <= ctrl;
      res_valid <= ctrl_q.valid && !ctrl_q.first;
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (ctrl_q.valid) begin
      acc <= ctrl_q.first ? prod : acc - prod;
    end
  end

endmodule

FILE: rtl/primitive_point_coverage_test_unit.sv
// Top level: triangle assembly, sequencer and coverage decision.
// A vertex completing no triangle is taken in the idle state; one closing a triangle goes through
// the request, 6 issues to the shared 18x18 multiplier, its pipeline registers and a compare.
// After the last vertex, the finish state registers the result on the master side.
// A new vertex is taken while a result still waits on the master side.
// rst is synchronous: it clears batch state, trace registers and the output valid.
`include "primitive_point_coverage_test_unit_macros.svh"

module primitive_point_coverage_test_unit #(
  parameter int MAX_TRIANGLES = ppct_pkg::MAX_TRIANGLES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppct_pkg::ADDR_W-1:0]  paddr,
  input  logic [ppct_pkg::DATA_W-1:0]  pwdata,
  output logic [ppct_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [31:0]                  s_tdata,   // vertex_x, vertex_y
  input  logic [1:0]                   s_tuser,   // prim_kind
  input  logic                         s_tlast,   // last_vertex
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [15:0]                  m_tdata    // hit, triangle_count, zero pad
);
  import ppct_pkg::*;

  localparam logic [TRI_CMP_W-1:0] MAX_TRI = TRI_CMP_W'(MAX_TRIANGLES);
  localparam int CAP_INT = (MAX_TRIANGLES < COUNT_FIELD_MAX) ? MAX_TRIANGLES : COUNT_FIELD_MAX;
  localparam logic [CNT_W-1:0] TRI_CAP = CNT_W'(CAP_INT);

  logic [TRACE_W-1:0] trace_x;
  logic [TRACE_W-1:0] trace_y;

  state_t state, state_next;

  logic [31:0]       pivot_vertex, older_vertex, newer_vertex;
  kind_t             batch_kind;
  logic [CNT_W-1:0]  vertex_counter;
  logic [1:0]        mod3;
  logic [TRI_W-1:0]  div3;
  logic              hit_seen;
  logic              last_q;

  logic [STEP_W-1:0] step;
  logic [1:0]        res_idx;

  opnd_t e0x, e0y, e1x, e1y, px, py;
  prod_t d_q, un_q, vn_q;

  mac_ctrl_t mac_ctrl;
  opnd_t     mac_a, mac_b;
  logic      mac_res_valid;
  prod_t     mac_acc;

  logic              accept;
  kind_t             kind_eff;
  logic              not_sat;
  logic [TRI_CMP_W-1:0] idx_m2;
  logic              list_ok, span_ok, do_test;
  logic [31:0]       a_vtx;
  opnd_t             tx16, ty16;
  logic              inside_hit;
  logic signed [SUM_W-1:0] uv_sum, d_ext;
  logic [CNT_W-1:0]  tris_raw, tris_sel;
  logic              out_hit;
  logic              fin_load;

  ppct_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .trace_x (trace_x),
    .trace_y (trace_y)
  );

  ppct_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (mac_ctrl),
    .op_a      (mac_a),
    .op_b      (mac_b),
    .res_valid (mac_res_valid),
    .acc       (mac_acc)
  );

  // triangle assembly decisions for the vertex on the slave side
  always_comb begin
    accept   = s_tvalid && s_tready;
    kind_eff = (vertex_counter == '0) ? kind_t'(s_tuser) : batch_kind;
    not_sat  = vertex_counter != VCOUNT_MAX;
    idx_m2   = TRI_CMP_W'(vertex_counter) - TRI_CMP_W'(2);
    list_ok  = (mod3 == 2'd2) && (TRI_CMP_W'(div3) < MAX_TRI);
    span_ok  = (vertex_counter >= CNT_W'(2)) && (idx_m2 < MAX_TRI);
    case (kind_eff) inside
      KIND_LIST:              do_test = not_sat && list_ok;
      KIND_STRIP, KIND_FAN:   do_test = not_sat && span_ok;
      default:                do_test = 1'b0;
    endcase
    a_vtx = (kind_eff == KIND_FAN) ? pivot_vertex : older_vertex;
    tx16  = opnd_t'({trace_x, 4'b0000});
    ty16  = opnd_t'({trace_y, 4'b0000});
  end

  // strict inside test without division
  always_comb begin
    uv_sum = SUM_W'(un_q) + SUM_W'(vn_q);
    d_ext  = SUM_W'(d_q);
    inside_hit = ((d_q > 0) && (un_q > 0) && (vn_q > 0) && (uv_sum < d_ext)) ||
                 ((d_q < 0) && (un_q < 0) && (vn_q < 0) && (uv_sum > d_ext));
  end

  // batch result
  always_comb begin
    case (batch_kind)
      KIND_LIST:   tris_raw = CNT_W'(div3);
      KIND_ALWAYS: tris_raw = vertex_counter;
      default:     tris_raw = (vertex_counter >= CNT_W'(2)) ?
                              vertex_counter - CNT_W'(2) : '0;
    endcase
    tris_sel = (tris_raw > TRI_CAP) ? TRI_CAP : tris_raw;
    out_hit  = (batch_kind == KIND_ALWAYS) || hit_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    fin_load   = 1'b0;
    mac_ctrl   = '0;
    mac_a      = e0x;
    mac_b      = e1y;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (accept) begin
          if (do_test) begin
            state_next = ST_MUL;
          end else if (s_tlast) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_MUL: begin
        mac_ctrl.valid = step < MUL_STEPS;
        mac_ctrl.first = !step[0];
        case (step)
          3'd0:    begin mac_a = e0x; mac_b = e1y; end
          3'd1:    begin mac_a = e0y; mac_b = e1x; end
          3'd2:    begin mac_a = px;  mac_b = e1y; end
          3'd3:    begin mac_a = py;  mac_b = e1x; end
          3'd4:    begin mac_a = e0x; mac_b = py;  end
          default: begin mac_a = e0y; mac_b = px;  end
        endcase
        if (mac_res_valid && res_idx == 2'd2) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = last_q ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        fin_load = !m_tvalid || m_tready;
        if (fin_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= '0;
      res_idx <= '0;
    end else if (accept) begin
      step    <= '0;
      res_idx <= '0;
    end else if (state == ST_MUL) begin
      if (step < MUL_STEPS) begin
        step <= step + STEP_W'(1);
      end
      if (mac_res_valid) begin
        res_idx <= res_idx + 2'd1;
      end
    end
  end

  // operands and cross product terms
  always_ff @(posedge clk) begin
    if (accept) begin
      e0x <= coord_ext(s_tdata[15:0])  - coord_ext(a_vtx[15:0]);
      e0y <= coord_ext(s_tdata[31:16]) - coord_ext(a_vtx[31:16]);
      e1x <= coord_ext(newer_vertex[15:0])  - coord_ext(a_vtx[15:0]);
      e1y <= coord_ext(newer_vertex[31:16]) - coord_ext(a_vtx[31:16]);
      px  <= tx16 - coord_ext(a_vtx[15:0]);
      py  <= ty16 - coord_ext(a_vtx[31:16]);
    end
    if (state == ST_MUL && mac_res_valid) begin
      case (res_idx)
        2'd0:    d_q  <= mac_acc;
        2'd1:    un_q <= mac_acc;
        default: vn_q <= mac_acc;
      endcase
    end
  end

  // batch state
  always_ff @(posedge clk) begin
    if (rst || fin_load) begin
      pivot_vertex   <= '0;
      older_vertex   <= '0;
      newer_vertex   <= '0;
      batch_kind     <= KIND_LIST;
      vertex_counter <= '0;
      mod3           <= '0;
      div3           <= '0;
      hit_seen       <= 1'b0;
      last_q         <= 1'b0;
    end else if (accept) begin
      if (vertex_counter == '0) begin
        batch_kind   <= kind_t'(s_tuser);
        pivot_vertex <= s_tdata;
      end
      if (not_sat) begin
        vertex_counter <= vertex_counter + CNT_W'(1);
        if (mod3 == 2'd2) begin
          mod3 <= '0;
          div3 <= div3 + TRI_W'(1);
        end else begin
          mod3 <= mod3 + 2'd1;
        end
      end
      older_vertex <= newer_vertex;
      newer_vertex <= s_tdata;
      last_q       <= s_tlast;
    end else if (state == ST_EVAL && inside_hit) begin
      hit_seen <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      m_tdata <= {2'b00, tris_sel[TRI_W-1:0], out_hit};
    end
  end

  `PPCT_ASSERT_NEXT(a_mul_to_eval, clk, rst,
    state == ST_MUL && mac_res_valid && res_idx == 2'd2, state == ST_EVAL,
    "third term did not start evaluation")
  `PPCT_ASSERT_SAME(a_eval_quiet, clk, rst, state == ST_EVAL, !mac_res_valid,
    "multiplier result arrived during evaluation")
  `PPCT_ASSERT_NEXT(a_sat_hold, clk, rst, accept && vertex_counter == VCOUNT_MAX,
    vertex_counter == VCOUNT_MAX, "saturated vertex counter moved")
  `PPCT_ASSERT_NEXT(a_fin_hold, clk, rst, state == ST_FIN && m_tvalid && !m_tready,
    state == ST_FIN && m_tvalid, "pending result lost while stalled")

endmodule
